// ----- hdl/awls_pkg.sv -----
// Shared constants and control types for the windowed audio level meter.
// No dependencies; awls_acc, awls_calc and the top level refer to this package by scoped names.

package awls_pkg;

  localparam int CNT_W = 16;   // sample, tick and empty-read counters
  localparam int CFG_W = 16;   // widest configuration register
  localparam int OUT_W = 16;   // statistic fields of a result
  localparam int WIN_W = 32;   // window number

  // item kinds
  localparam logic [1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [1:0] FUNC_TICK   = 2'd1;
  localparam logic [1:0] FUNC_EMPTY  = 2'd2;

  // configuration register indexes
  localparam logic [0:0] REG_WINDOW_SAMPLES = 1'b0;
  localparam logic [0:0] REG_WINDOW_MS      = 1'b1;

  localparam logic [CFG_W-1:0] WINDOW_SAMPLES_RST = 16'd16000;
  localparam logic [CFG_W-1:0] WINDOW_MS_RST      = 16'd2000;

  // top level -> close-out sequencer
  typedef struct packed {
    logic start;  // window closed, snapshot valid this cycle
    logic ack;    // results taken into the output register
  } calc_ctl_t;

  // close-out sequencer -> top level
  typedef struct packed {
    logic done;   // results valid, held until ack
    logic empty;  // window held no samples
  } calc_stat_t;

endpackage

// ----- hdl/awls_if.sv -----
// Valid/ready channel interfaces for item input and result output.
// Depends on nothing; widths of the result follow awls_pkg sizes.

interface awls_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    func;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, func, sample, input ready);
  modport sink   (input valid, func, sample, output ready);
endinterface

interface awls_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        window_index;
  logic [15:0]        sample_count;
  logic               no_samples;
  logic signed [15:0] mean_level;
  logic [15:0]        ac_rms;
  logic [15:0]        avg_abs;
  logic [15:0]        peak_abs;
  logic signed [15:0] min_sample;
  logic signed [15:0] max_sample;
  logic [15:0]        empty_reads;

  modport source (output valid, window_index, sample_count, no_samples, mean_level,
                  ac_rms, avg_abs, peak_abs, min_sample, max_sample, empty_reads,
                  input ready);
  modport sink   (input valid, window_index, sample_count, no_samples, mean_level,
                  ac_rms, avg_abs, peak_abs, min_sample, max_sample, empty_reads,
                  output ready);
endinterface

// ----- hdl/audio_window_level_statistics.sv -----
// Top level of the windowed mean / AC RMS / peak meter.
// Depends on awls_pkg, awls_if (channels), awls_acc and awls_calc.
//
//   channel  | dir | transfer when      | payload
//   ---------+-----+--------------------+----------------------------------------------
//   in_if    | in  | valid & ready      | func, sample
//   out_if   | out | valid & ready      | window statistics, one per closed window
//   cfg      | in  | cfg_we_i           | cfg_idx_i selects window_samples / window_ms
//
// A sample, tick or empty read that does not close a window is taken while ready stays high.
// An item that closes a window holds ready low while the close-out runs on the shared
// adder in awls_calc; for an empty window the arithmetic is skipped.
// The output register frees the input side: items are taken while a result waits,
// unless another window closes, which then waits for out_if.ready before finishing.
// Reset is asynchronous, active low, and loads window_samples 16000, window_ms 2000.

module audio_window_level_statistics #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_idx_i,
  input  logic [awls_pkg::CFG_W-1:0]    cfg_data_i,
  awls_in_if.sink                       in_if,
  awls_out_if.source                    out_if
);

  localparam int CW    = awls_pkg::CNT_W;
  localparam int OW    = awls_pkg::OUT_W;
  localparam int WW    = awls_pkg::WIN_W;
  localparam int SW    = SAMPLE_BITS;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic                      st_q;
  logic [awls_pkg::CFG_W-1:0] ws_q, wms_q;
  logic [WW-1:0]             win_q;
  logic                      out_valid_q;

  logic [WW-1:0]             hold_idx_q;
  logic [CW-1:0]             hold_cnt_q, hold_empty_q;
  logic signed [SW-1:0]      hold_min_q, hold_max_q;
  logic [SW-1:0]             hold_peak_q;

  logic                      take, is_smp, is_tick, close, load;

  logic signed [SW+15:0]     acc_sum;
  logic [2*SW+13:0]          acc_sq;
  logic [SW+14:0]            acc_abs;
  logic signed [SW-1:0]      acc_min, acc_max;
  logic [SW-1:0]             acc_peak;
  logic [CW-1:0]             acc_count, acc_ms, acc_empty;

  awls_pkg::calc_ctl_t       ctl;
  awls_pkg::calc_stat_t      stat;
  logic [OW-1:0]             calc_mean, calc_rms, calc_avg;

  assign in_if.ready = (st_q == ST_IDLE);
  assign take        = in_if.valid & in_if.ready;
  assign is_smp      = (in_if.func == awls_pkg::FUNC_SAMPLE);
  assign is_tick     = (in_if.func == awls_pkg::FUNC_TICK);
  // close check uses the counts after this item
  assign close       = take & (is_smp | is_tick) & ((acc_count >= ws_q) | (acc_ms >= wms_q));
  assign load        = (st_q == ST_BUSY) & stat.done & (~out_valid_q | out_if.ready);

  assign ctl.start   = close;
  assign ctl.ack     = load;

  awls_acc #(.SAMPLE_BITS(SAMPLE_BITS)) u_acc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .clear_i   (close),
    .func_i    (in_if.func),
    .sample_i  (in_if.sample),
    .sum_o     (acc_sum),
    .sum_sq_o  (acc_sq),
    .sum_abs_o (acc_abs),
    .min_o     (acc_min),
    .max_o     (acc_max),
    .peak_o    (acc_peak),
    .count_o   (acc_count),
    .ms_o      (acc_ms),
    .empty_o   (acc_empty)
  );

  awls_calc #(.SAMPLE_BITS(SAMPLE_BITS)) u_calc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .stat_o    (stat),
    .count_i   (acc_count),
    .sum_i     (acc_sum),
    .sum_sq_i  (acc_sq),
    .sum_abs_i (acc_abs),
    .mean_o    (calc_mean),
    .rms_o     (calc_rms),
    .avg_o     (calc_avg)
  );

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      ws_q        <= awls_pkg::WINDOW_SAMPLES_RST;
      wms_q       <= awls_pkg::WINDOW_MS_RST;
      win_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          awls_pkg::REG_WINDOW_SAMPLES: ws_q  <= cfg_data_i;
          awls_pkg::REG_WINDOW_MS:      wms_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (st_q)
        ST_IDLE: begin
          if (close) begin
            st_q  <= ST_BUSY;
            win_q <= win_q + 1'b1;
          end
        end
        ST_BUSY: begin
          if (load) st_q <= ST_IDLE;
        end
        default: st_q <= ST_IDLE;
      endcase
      if (load) out_valid_q <= 1'b1;
      else if (out_if.ready) out_valid_q <= 1'b0;
    end
  end

  // snapshot of the fields that need no arithmetic
  always_ff @(posedge clk_i) begin
    if (close) begin
      hold_idx_q   <= win_q;
      hold_cnt_q   <= acc_count;
      hold_empty_q <= acc_empty;
      hold_min_q   <= acc_min;
      hold_max_q   <= acc_max;
      hold_peak_q  <= acc_peak;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_if.window_index <= hold_idx_q;
      out_if.sample_count <= hold_cnt_q;
      out_if.empty_reads  <= hold_empty_q;
      out_if.no_samples   <= stat.empty;
      out_if.mean_level   <= calc_mean;
      out_if.ac_rms       <= calc_rms;
      out_if.avg_abs      <= calc_avg;
      out_if.peak_abs     <= stat.empty ? '0 : OW'(hold_peak_q);
      out_if.min_sample   <= stat.empty ? '0 : OW'(hold_min_q);
      out_if.max_sample   <= stat.empty ? '0 : OW'(hold_max_q);
    end
  end

  assign out_if.valid = out_valid_q;

endmodule

// ----- hdl/awls_alu.sv -----
// Shared adder/subtractor used by every step of the window close-out.
// Carry out on subtract means a_i >= b_i. No package dependency.

module awls_alu #(
  parameter int W = 62
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         sub_i,
  output logic [W-1:0] res_o,
  output logic         cout_o
);

  logic [W-1:0] b_eff;

  assign b_eff = sub_i ? ~b_i : b_i;
  assign {cout_o, res_o} = {1'b0, a_i} + {1'b0, b_eff} + (W+1)'(sub_i);

endmodule

// ----- hdl/awls_acc.sv -----
// Per-item accumulators: sums, extremes and saturating counters of one window.
// Uses awls_pkg for item codes and counter width. Outputs are the post-item values.

module awls_acc #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          take_i,
  input  logic                          clear_i,
  input  logic [1:0]                    func_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic signed [SAMPLE_BITS+15:0] sum_o,
  output logic [2*SAMPLE_BITS+13:0]     sum_sq_o,
  output logic [SAMPLE_BITS+14:0]       sum_abs_o,
  output logic signed [SAMPLE_BITS-1:0] min_o,
  output logic signed [SAMPLE_BITS-1:0] max_o,
  output logic [SAMPLE_BITS-1:0]        peak_o,
  output logic [awls_pkg::CNT_W-1:0]    count_o,
  output logic [awls_pkg::CNT_W-1:0]    ms_o,
  output logic [awls_pkg::CNT_W-1:0]    empty_o
);

  localparam int SW    = SAMPLE_BITS;
  localparam int SUM_W = SW + 16;
  localparam int MAG_W = SW + 15;
  localparam int SQ_W  = 2 * SW + 14;
  localparam int CW    = awls_pkg::CNT_W;
  localparam logic signed [SW-1:0] MIN_RST = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] MAX_RST = {1'b1, {(SW-1){1'b0}}};

  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [SQ_W-1:0]         sq_q, sq_d;
  logic [MAG_W-1:0]        abs_q, abs_d;
  logic signed [SW-1:0]    min_q, min_d, max_q, max_d;
  logic [SW-1:0]           peak_q, peak_d;
  logic [CW-1:0]           count_q, count_d, ms_q, ms_d, empty_q, empty_d;
  logic [SW-1:0]           mag;
  logic [2*SW-1:0]         mag_sq;

  always_comb begin
    mag     = sample_i[SW-1] ? SW'(~sample_i + SW'(1)) : SW'(sample_i);
    mag_sq  = {{SW{1'b0}}, mag} * {{SW{1'b0}}, mag};
    sum_d   = sum_q;
    sq_d    = sq_q;
    abs_d   = abs_q;
    min_d   = min_q;
    max_d   = max_q;
    peak_d  = peak_q;
    count_d = count_q;
    ms_d    = ms_q;
    empty_d = empty_q;
    case (func_i)
      awls_pkg::FUNC_SAMPLE: begin
        sum_d  = sum_q + SUM_W'(sample_i);
        sq_d   = sq_q + SQ_W'(mag_sq);
        abs_d  = abs_q + MAG_W'(mag);
        min_d  = (sample_i < min_q) ? sample_i : min_q;
        max_d  = (sample_i > max_q) ? sample_i : max_q;
        peak_d = (mag > peak_q) ? mag : peak_q;
        if (count_q != {CW{1'b1}}) count_d = count_q + 1'b1;
      end
      awls_pkg::FUNC_TICK: begin
        if (ms_q != {CW{1'b1}}) ms_d = ms_q + 1'b1;
      end
      awls_pkg::FUNC_EMPTY: begin
        if (empty_q != {CW{1'b1}}) empty_d = empty_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      sq_q    <= '0;
      abs_q   <= '0;
      min_q   <= MIN_RST;
      max_q   <= MAX_RST;
      peak_q  <= '0;
      count_q <= '0;
      ms_q    <= '0;
      empty_q <= '0;
    end else if (take_i) begin
      if (clear_i) begin
        sum_q   <= '0;
        sq_q    <= '0;
        abs_q   <= '0;
        min_q   <= MIN_RST;
        max_q   <= MAX_RST;
        peak_q  <= '0;
        count_q <= '0;
        ms_q    <= '0;
        empty_q <= '0;
      end else begin
        sum_q   <= sum_d;
        sq_q    <= sq_d;
        abs_q   <= abs_d;
        min_q   <= min_d;
        max_q   <= max_d;
        peak_q  <= peak_d;
        count_q <= count_d;
        ms_q    <= ms_d;
        empty_q <= empty_d;
      end
    end
  end

  assign sum_o     = sum_d;
  assign sum_sq_o  = sq_d;
  assign sum_abs_o = abs_d;
  assign min_o     = min_d;
  assign max_o     = max_d;
  assign peak_o    = peak_d;
  assign count_o   = count_d;
  assign ms_o      = ms_d;
  assign empty_o   = empty_d;

endmodule

// ----- hdl/awls_calc.sv -----
// Window close-out sequencer: mean, AC RMS and average magnitude, one adder step per cycle.
// Uses awls_pkg control types and awls_alu for every adder step.

module awls_calc #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  awls_pkg::calc_ctl_t            ctl_i,
  output awls_pkg::calc_stat_t           stat_o,
  input  logic [awls_pkg::CNT_W-1:0]     count_i,
  input  logic signed [SAMPLE_BITS+15:0] sum_i,
  input  logic [2*SAMPLE_BITS+13:0]      sum_sq_i,
  input  logic [SAMPLE_BITS+14:0]        sum_abs_i,
  output logic [awls_pkg::OUT_W-1:0]     mean_o,
  output logic [awls_pkg::OUT_W-1:0]     rms_o,
  output logic [awls_pkg::OUT_W-1:0]     avg_o
);

  localparam int CW     = awls_pkg::CNT_W;
  localparam int OW     = awls_pkg::OUT_W;
  localparam int SUM_W  = SAMPLE_BITS + 16;
  localparam int MAG_W  = SAMPLE_BITS + 15;   // also the root width
  localparam int AW     = 2 * MAG_W;           // n*sum_sq and sum^2 both fit
  localparam int REM_W  = MAG_W + 2;
  localparam int STEP_W = $clog2(MAG_W + 1);

  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_MULX = 4'd1;   // n * sum_sq, shift-add
  localparam logic [3:0] PH_MULS = 4'd2;   // |sum| * |sum|, shift-add
  localparam logic [3:0] PH_SUB  = 4'd3;   // variance numerator, clamped at zero
  localparam logic [3:0] PH_SQRT = 4'd4;   // two bits of radicand per step
  localparam logic [3:0] PH_DIVR = 4'd5;   // root / n
  localparam logic [3:0] PH_DIVM = 4'd6;   // |sum| / n
  localparam logic [3:0] PH_DIVA = 4'd7;   // sum_abs / n
  localparam logic [3:0] PH_DONE = 4'd8;

  logic [3:0]        ph_q;
  logic [STEP_W-1:0] step_q;
  logic              empty_q;

  logic [CW-1:0]     n_q;
  logic              neg_q;
  logic [MAG_W-1:0]  mag_q, abs_q, mp_q, root_q, quo_q;
  logic [AW-1:0]     a_q, x_q, mc_q, num_q;
  logic [REM_W-1:0]  rem_q;
  logic [OW-1:0]     mean_q, rms_q, avg_q;

  logic [AW-1:0]     alu_a, alu_b, alu_res;
  logic              alu_sub, alu_cout;
  logic [REM_W:0]    sq_rem;
  logic [REM_W-1:0]  sq_trial;
  logic [CW:0]       dv_rem;
  logic [MAG_W-1:0]  quo_nx;
  logic              last;

  awls_alu #(.W(AW)) u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .sub_i  (alu_sub),
    .res_o  (alu_res),
    .cout_o (alu_cout)
  );

  always_comb begin
    sq_rem   = {rem_q[MAG_W:0], num_q[AW-1 -: 2]};
    sq_trial = {root_q, 2'b01};
    dv_rem   = {rem_q[CW-1:0], quo_q[MAG_W-1]};
    alu_a    = '0;
    alu_b    = '0;
    alu_sub  = 1'b0;
    case (ph_q)
      PH_MULX, PH_MULS: begin
        alu_a = a_q;
        alu_b = mp_q[0] ? mc_q : '0;
      end
      PH_SUB: begin
        alu_a   = x_q;
        alu_b   = a_q;
        alu_sub = 1'b1;
      end
      PH_SQRT: begin
        alu_a   = AW'(sq_rem);
        alu_b   = AW'(sq_trial);
        alu_sub = 1'b1;
      end
      PH_DIVR, PH_DIVM, PH_DIVA: begin
        alu_a   = AW'(dv_rem);
        alu_b   = AW'(n_q);
        alu_sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign quo_nx = {quo_q[MAG_W-2:0], alu_cout};
  assign last   = (step_q == STEP_W'(1));

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_IDLE;
      step_q  <= '0;
      empty_q <= 1'b0;
    end else begin
      case (ph_q)
        PH_IDLE: begin
          if (ctl_i.start) begin
            empty_q <= (count_i == '0);
            if (count_i == '0) begin
              ph_q <= PH_DONE;
            end else begin
              ph_q   <= PH_MULX;
              step_q <= STEP_W'(CW);
            end
          end
        end
        PH_MULX: begin
          if (last) begin
            ph_q   <= PH_MULS;
            step_q <= STEP_W'(MAG_W);
          end else step_q <= step_q - 1'b1;
        end
        PH_MULS: begin
          if (last) ph_q <= PH_SUB;
          else step_q <= step_q - 1'b1;
        end
        PH_SUB: begin
          ph_q   <= PH_SQRT;
          step_q <= STEP_W'(MAG_W);
        end
        PH_SQRT: begin
          if (last) begin
            ph_q   <= PH_DIVR;
            step_q <= STEP_W'(MAG_W);
          end else step_q <= step_q - 1'b1;
        end
        PH_DIVR: begin
          if (last) begin
            ph_q   <= PH_DIVM;
            step_q <= STEP_W'(MAG_W);
          end else step_q <= step_q - 1'b1;
        end
        PH_DIVM: begin
          if (last) begin
            ph_q   <= PH_DIVA;
            step_q <= STEP_W'(MAG_W);
          end else step_q <= step_q - 1'b1;
        end
        PH_DIVA: begin
          if (last) ph_q <= PH_DONE;
          else step_q <= step_q - 1'b1;
        end
        PH_DONE: begin
          if (ctl_i.ack) ph_q <= PH_IDLE;
        end
        default: ph_q <= PH_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (ph_q)
      PH_IDLE: begin
        if (ctl_i.start) begin
          n_q    <= count_i;
          neg_q  <= sum_i[SUM_W-1];
          mag_q  <= sum_i[SUM_W-1] ? MAG_W'(-sum_i) : MAG_W'(sum_i);
          abs_q  <= sum_abs_i;
          a_q    <= '0;
          mc_q   <= AW'(sum_sq_i);
          mp_q   <= MAG_W'(count_i);
          mean_q <= '0;
          rms_q  <= '0;
          avg_q  <= '0;
        end
      end
      PH_MULX: begin
        if (last) begin
          x_q  <= alu_res;
          a_q  <= '0;
          mc_q <= AW'(mag_q);
          mp_q <= mag_q;
        end else begin
          a_q  <= alu_res;
          mc_q <= mc_q << 1;
          mp_q <= mp_q >> 1;
        end
      end
      PH_MULS: begin
        a_q  <= alu_res;
        mc_q <= mc_q << 1;
        mp_q <= mp_q >> 1;
      end
      PH_SUB: begin
        num_q  <= alu_cout ? alu_res : '0;
        rem_q  <= '0;
        root_q <= '0;
      end
      PH_SQRT: begin
        num_q <= num_q << 2;
        if (last) begin
          quo_q <= {root_q[MAG_W-2:0], alu_cout};
          rem_q <= '0;
        end else if (alu_cout) begin
          rem_q  <= alu_res[REM_W-1:0];
          root_q <= {root_q[MAG_W-2:0], 1'b1};
        end else begin
          rem_q  <= sq_rem[REM_W-1:0];
          root_q <= {root_q[MAG_W-2:0], 1'b0};
        end
      end
      PH_DIVR, PH_DIVM, PH_DIVA: begin
        if (last) begin
          rem_q <= '0;
          case (ph_q)
            PH_DIVR: begin
              rms_q <= OW'(quo_nx);
              quo_q <= mag_q;
            end
            PH_DIVM: begin
              // truncation toward zero: divide the magnitude, then restore the sign
              mean_q <= neg_q ? OW'(-quo_nx) : OW'(quo_nx);
              quo_q  <= abs_q;
            end
            default: avg_q <= OW'(quo_nx);
          endcase
        end else begin
          quo_q <= quo_nx;
          rem_q <= alu_cout ? REM_W'(alu_res[CW:0]) : REM_W'(dv_rem);
        end
      end
      default: ;
    endcase
  end

  assign stat_o.done  = (ph_q == PH_DONE);
  assign stat_o.empty = empty_q;
  assign mean_o       = mean_q;
  assign rms_o        = rms_q;
  assign avg_o        = avg_q;

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for audio_window_level_statistics: directed and random runs.
// Depends on awls_pkg, the awls_in_if / awls_out_if channel interfaces and the top level from hdl/.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import awls_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int CLOSE_CYCLES = 5 * 16 + 94;
  localparam int HOLD_CYCLES = 1500;

  typedef struct packed {
    logic [31:0]        window_index;
    logic [15:0]        sample_count;
    logic               no_samples;
    logic signed [15:0] mean_level;
    logic [15:0]        ac_rms;
    logic [15:0]        avg_abs;
    logic [15:0]        peak_abs;
    logic signed [15:0] min_sample;
    logic signed [15:0] max_sample;
    logic [15:0]        empty_reads;
  } window_stats_t;

  // Mirrors the meter's window state and queues the statistics of every closed window.
  class level_meter_scoreboard;
    logic [15:0]        win_samples_reg;
    logic [15:0]        win_ms_reg;
    logic signed [32:0] sum;
    logic [46:0]        sum_sq;
    logic [31:0]        sum_abs;
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    logic [15:0]        peak;
    logic [15:0]        n_samples;
    logic [15:0]        n_ms;
    logic [15:0]        n_empty;
    logic [31:0]        window_no;
    window_stats_t      expected_windows[$];
    int                 mismatches;

    function new();
      win_samples_reg = WINDOW_SAMPLES_RST;
      win_ms_reg = WINDOW_MS_RST;
      window_no = '0;
      mismatches = 0;
      clear_window();
    endfunction

    function void clear_window();
      sum = '0;
      sum_sq = '0;
      sum_abs = '0;
      lo = 16'sh7fff;
      hi = 16'sh8000;
      peak = '0;
      n_samples = '0;
      n_ms = '0;
      n_empty = '0;
    endfunction

    function void set_register(logic [0:0] idx, logic [15:0] value);
      if (idx == REG_WINDOW_SAMPLES) begin
        win_samples_reg = value;
      end else begin
        win_ms_reg = value;
      end
    endfunction

    function int pending();
      return expected_windows.size();
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= x) r = t;
      end
      return r;
    endfunction

    function void close_window();
      window_stats_t w;
      longint s64;
      longint mean;
      longint unsigned n;
      longint unsigned mag;
      longint unsigned x;
      longint unsigned s2;
      longint unsigned spread;
      w = '0;
      w.window_index = window_no;
      w.sample_count = n_samples;
      w.empty_reads = n_empty;
      if (n_samples == 0) begin
        w.no_samples = 1'b1;
      end else begin
        n = n_samples;
        s64 = sum;
        mag = (s64 < 0) ? -s64 : s64;
        x = n * sum_sq;
        s2 = mag * mag;
        spread = (x >= s2) ? x - s2 : 0;
        mean = s64 / longint'(n);
        w.mean_level = mean[15:0];
        w.ac_rms = 16'(int_sqrt(spread) / n);
        w.avg_abs = 16'(sum_abs / n);
        w.peak_abs = peak;
        w.min_sample = lo;
        w.max_sample = hi;
      end
      expected_windows.push_back(w);
      window_no++;
      clear_window();
    endfunction

    function void note_item(logic [1:0] func, logic signed [15:0] s);
      logic [16:0] mag;
      if (func == FUNC_SAMPLE) begin
        mag = s[15] ? 17'd0 - {1'b1, s} : {1'b0, s};
        sum = sum + {{17{s[15]}}, s};
        sum_sq = sum_sq + mag * mag;
        sum_abs = sum_abs + mag;
        if (s < lo) lo = s;
        if (s > hi) hi = s;
        if (mag > peak) peak = mag[15:0];
        if (n_samples != 16'hffff) n_samples++;
      end else if (func == FUNC_TICK) begin
        if (n_ms != 16'hffff) n_ms++;
      end else begin
        // empty reads only count; the unused code does nothing
        if (func == FUNC_EMPTY && n_empty != 16'hffff) n_empty++;
        return;
      end
      if (n_samples >= win_samples_reg || n_ms >= win_ms_reg) close_window();
    endfunction

    function void check_result(window_stats_t got);
      window_stats_t want;
      string diffs;
      if (expected_windows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected window result: index %0d count %0d",
                   got.window_index, got.sample_count);
        return;
      end
      want = expected_windows.pop_front();
      diffs = "";
      if (got.window_index != want.window_index)
        diffs = {diffs, $sformatf(" window_index %0d/%0d", want.window_index, got.window_index)};
      if (got.sample_count != want.sample_count)
        diffs = {diffs, $sformatf(" sample_count %0d/%0d", want.sample_count, got.sample_count)};
      if (got.no_samples != want.no_samples)
        diffs = {diffs, $sformatf(" no_samples %0d/%0d", want.no_samples, got.no_samples)};
      if (got.mean_level != want.mean_level)
        diffs = {diffs, $sformatf(" mean_level %0d/%0d", want.mean_level, got.mean_level)};
      if (got.ac_rms != want.ac_rms)
        diffs = {diffs, $sformatf(" ac_rms %0d/%0d", want.ac_rms, got.ac_rms)};
      if (got.avg_abs != want.avg_abs)
        diffs = {diffs, $sformatf(" avg_abs %0d/%0d", want.avg_abs, got.avg_abs)};
      if (got.peak_abs != want.peak_abs)
        diffs = {diffs, $sformatf(" peak_abs %0d/%0d", want.peak_abs, got.peak_abs)};
      if (got.min_sample != want.min_sample)
        diffs = {diffs, $sformatf(" min_sample %0d/%0d", want.min_sample, got.min_sample)};
      if (got.max_sample != want.max_sample)
        diffs = {diffs, $sformatf(" max_sample %0d/%0d", want.max_sample, got.max_sample)};
      if (got.empty_reads != want.empty_reads)
        diffs = {diffs, $sformatf(" empty_reads %0d/%0d", want.empty_reads, got.empty_reads)};
      if (diffs != "") begin
        mismatches++;
        if (mismatches <= 10)
          $display("window %0d mismatch (expected/actual):%s", want.window_index, diffs);
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [0:0]        cfg_idx_i;
  logic [CFG_W-1:0]  cfg_data_i;

  awls_in_if #(.SAMPLE_BITS(16)) in_ch ();
  awls_out_if                    out_ch ();

  audio_window_level_statistics #(.SAMPLE_BITS(16)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  level_meter_scoreboard sb = new();

  bit tx_idling;
  bit rx_idling;
  bit rx_hold_req;
  int rx_hold_left;
  int rx_gap_left;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side: random stalls plus one long hold-off on request
  always @(posedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_left = HOLD_CYCLES;
      rx_hold_req = 1'b0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_ch.ready <= 1'b0;
    end else if (rx_gap_left != 0) begin
      rx_gap_left--;
      out_ch.ready <= 1'b0;
    end else if (rx_idling && $urandom_range(0, 4) == 0) begin
      rx_gap_left = $urandom_range(1, 7) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // outputs are stable between negedge and the next posedge, where the transfer happens
  always @(negedge clk_i) begin
    window_stats_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got.window_index = out_ch.window_index;
      got.sample_count = out_ch.sample_count;
      got.no_samples = out_ch.no_samples;
      got.mean_level = out_ch.mean_level;
      got.ac_rms = out_ch.ac_rms;
      got.avg_abs = out_ch.avg_abs;
      got.peak_abs = out_ch.peak_abs;
      got.min_sample = out_ch.min_sample;
      got.max_sample = out_ch.max_sample;
      got.empty_reads = out_ch.empty_reads;
      sb.check_result(got);
    end
  end

  task automatic send_item(input logic [1:0] f, input logic signed [15:0] s);
    if (tx_idling && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= f;
    in_ch.sample <= s;
    do @(negedge clk_i); while (!in_ch.ready);
    @(posedge clk_i);
    sb.note_item(f, s);
  endtask

  // stop offering, let every closed window come out and the close-out logic settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (CLOSE_CYCLES + 20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_register(idx, value);
    @(posedge clk_i);
  endtask

  task automatic pick_item(output logic [1:0] f, output logic signed [15:0] s);
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 60) f = FUNC_SAMPLE;
    else if (kind < 78) f = FUNC_TICK;
    else if (kind < 93) f = FUNC_EMPTY;
    else f = FUNC_UNUSED;
    case ($urandom_range(0, 7))
      0: s = 16'sh8000;
      1: s = 16'sh7fff;
      2: s = 16'($urandom_range(0, 64)) - 16'sd32;
      default: s = 16'($urandom);
    endcase
  endtask

  task automatic run_directed();
    write_reg(REG_WINDOW_SAMPLES, 16'd4);
    write_reg(REG_WINDOW_MS, 16'd3);
    // extremes of the sample; the fourth sample closes the window
    send_item(FUNC_SAMPLE, 16'sh7fff);
    send_item(FUNC_SAMPLE, 16'sh8000);
    send_item(FUNC_SAMPLE, 16'sd0);
    send_item(FUNC_SAMPLE, -16'sd1);
    // window closed by ticks with no samples in it
    send_item(FUNC_TICK, 16'sd0);
    send_item(FUNC_EMPTY, 16'sh7fff);
    send_item(FUNC_UNUSED, 16'sh8000);
    send_item(FUNC_TICK, 16'sd0);
    send_item(FUNC_TICK, 16'sd0);
    // sample limit lowered below the running count
    send_item(FUNC_SAMPLE, 16'sd1);
    send_item(FUNC_SAMPLE, -16'sd2);
    wait_idle();
    write_reg(REG_WINDOW_SAMPLES, 16'd1);
    send_item(FUNC_SAMPLE, 16'sd100);
    // zero limits close at the next check
    wait_idle();
    write_reg(REG_WINDOW_SAMPLES, 16'd0);
    send_item(FUNC_TICK, 16'sd0);
    wait_idle();
    write_reg(REG_WINDOW_MS, 16'd0);
    write_reg(REG_WINDOW_SAMPLES, 16'd5);
    send_item(FUNC_EMPTY, 16'sd0);
    send_item(FUNC_TICK, 16'sd0);
    wait_idle();
    write_reg(REG_WINDOW_MS, 16'd2);
    send_item(FUNC_SAMPLE, 16'sd12345);
    send_item(FUNC_TICK, 16'sd0);
    send_item(FUNC_SAMPLE, -16'sd7);
    send_item(FUNC_TICK, 16'sd0);
    wait_idle();
  endtask

  task automatic run_random();
    logic [15:0]        ws;
    logic [15:0]        wm;
    logic [1:0]         f;
    logic signed [15:0] s;
    int                 counted;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin ws = 16'd1; wm = 16'hffff; end
        1: begin ws = 16'($urandom_range(2, 40)); wm = 16'($urandom_range(1, 30)); end
        2: begin ws = 16'hffff; wm = 16'd1; end
        3: begin ws = 16'($urandom_range(1, 12)); wm = 16'($urandom_range(2, 10)); end
        4: begin ws = 16'($urandom); wm = 16'($urandom_range(1, 6)); end
        default: begin ws = 16'($urandom_range(2, 20)); wm = 16'($urandom_range(2, 20)); end
      endcase
      wait_idle();
      write_reg(REG_WINDOW_SAMPLES, ws);
      write_reg(REG_WINDOW_MS, wm);
      tx_idling = (phase != 3 && phase != 5);
      rx_idling = (phase != 3 && phase != 5);
      // every sample closes a window here, so a held-off receiver backs up the input
      if (phase == 0) rx_hold_req = 1'b1;
      counted = 0;
      while (counted < 250) begin
        pick_item(f, s);
        send_item(f, s);
        counted++;
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_SAMPLE;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_WINDOW_SAMPLES;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    tx_idling = 1'b1;
    rx_idling = 1'b1;
    rx_hold_req = 1'b0;
    rx_hold_left = 0;
    rx_gap_left = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    tx_idling = 1'b1;
    run_random();
    wait_idle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/awls_pkg.sv
hdl/awls_if.sv
hdl/awls_alu.sv
hdl/awls_acc.sv
hdl/awls_calc.sv
hdl/audio_window_level_statistics.sv
bench/testbench.sv
